>>> rtl/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg: shared types and character helpers for the percent-escape codec
// Job format passed from the classifier to the emitter, queue status and
// the byte classification functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

    // Character codes
    localparam logic [7:0] C_PCT   = 8'h25;  // '%'
    localparam logic [7:0] C_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] C_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] C_UNDER = 8'h5F;  // '_'
    localparam logic [7:0] C_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] C_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] C_NINE  = 8'h39;  // '9'
    localparam logic [7:0] C_UA    = 8'h41;  // 'A'
    localparam logic [7:0] C_UF    = 8'h46;  // 'F'
    localparam logic [7:0] C_UZ    = 8'h5A;  // 'Z'
    localparam logic [7:0] C_LA    = 8'h61;  // 'a'
    localparam logic [7:0] C_LZ    = 8'h7A;  // 'z'
    localparam logic [7:0] C_ALPHA_OFS = 8'h37;  // 'A' - 10

    // Mode register values
    localparam logic C_MODE_ENC = 1'b0;
    localparam logic C_MODE_DEC = 1'b1;

    // Pending escape counts in decode mode
    localparam logic [1:0] C_PEND_NONE = 2'd0;
    localparam logic [1:0] C_PEND_PCT  = 2'd1;
    localparam logic [1:0] C_PEND_HEX  = 2'd2;

    // Job queue geometry
    localparam int C_Q_DEPTH = 2;
    localparam int C_Q_AW    = $clog2(C_Q_DEPTH);
    localparam int C_Q_CW    = $clog2(C_Q_DEPTH + 1);

    // One to three output bytes produced by one input word
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_hex_upper(input logic [7:0] c);
        return ((c >= C_ZERO) && (c <= C_NINE)) || ((c >= C_UA) && (c <= C_UF));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = (c <= C_NINE) ? (c - C_ZERO) : (c - C_ALPHA_OFS);
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (C_ZERO + {4'h0, v}) : (C_ALPHA_OFS + {4'h0, v});
    endfunction

    function automatic logic passes_encode(input logic [7:0] c);
        logic alnum;
        alnum = ((c >= C_ZERO) && (c <= C_NINE)) || ((c >= C_UA) && (c <= C_UZ))
             || ((c >= C_LA) && (c <= C_LZ));
        case (c)
            C_DASH, C_DOT, C_UNDER, C_TILDE,
            8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,   // ! # $ & ' ( )
            8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D,   // * + , / : ; =
            8'h3F, 8'h40, 8'h5B, 8'h5D: begin                  // ? @ [ ]
                return 1'b1;
            end
            default: begin
                return alnum;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/pec_if.sv
// ----------------------------------------------------------------------------
// pec_if: byte stream channels of the percent-escape codec
// Valid/ready channels carrying a byte and an end-of-string flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> rtl/pec_front.sv
// ----------------------------------------------------------------------------
// pec_front: input classifier
// Accepts input words, holds the mode register and the pending escape state,
// and turns each word that yields output into a job of one to three bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pec_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    pec_in_if.sink             i_in,
    input  wire pec_pkg::t_qstat i_qstat,
    output pec_pkg::t_push     o_push
);
    import pec_pkg::*;

    logic            r_mode;
    logic [1:0]      r_pend_cnt;
    logic [7:0]      r_pend_hex;
    logic [1:0]      n_pend_cnt;
    logic [7:0]      n_pend_hex;

    logic            w_acc;
    logic [7:0]      w_b;
    logic            w_rescan;
    logic [2:0][7:0] w_bytes;
    logic [1:0]      w_k;

    assign i_in.ready = !i_qstat.full;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_b        = i_in.in_byte;

    // Classify the word and build its output bytes
    always_comb begin
        w_bytes    = '0;
        w_k        = 2'd0;
        w_rescan   = 1'b0;
        n_pend_cnt = r_pend_cnt;
        n_pend_hex = r_pend_hex;
        if (r_mode == C_MODE_ENC) begin
            if (passes_encode(w_b)) begin
                w_bytes[0] = w_b;
                w_k        = 2'd1;
            end else begin
                w_bytes[0] = C_PCT;
                w_bytes[1] = hex_digit(w_b[7:4]);
                w_bytes[2] = hex_digit(w_b[3:0]);
                w_k        = 2'd3;
            end
        end else begin
            case (r_pend_cnt)
                C_PEND_NONE: begin
                    w_rescan = 1'b1;
                end
                C_PEND_PCT: begin
                    if (is_hex_upper(w_b)) begin
                        n_pend_hex = w_b;
                        n_pend_cnt = C_PEND_HEX;
                    end else begin
                        // bad escape: release the '%' and look at this byte again
                        w_bytes[0] = C_PCT;
                        w_k        = 2'd1;
                        w_rescan   = 1'b1;
                    end
                end
                default: begin
                    if (is_hex_upper(w_b)) begin
                        w_bytes[0] = {hex_value(r_pend_hex), hex_value(w_b)};
                        w_k        = 2'd1;
                        n_pend_cnt = C_PEND_NONE;
                    end else begin
                        w_bytes[0] = C_PCT;
                        w_bytes[1] = r_pend_hex;
                        w_k        = 2'd2;
                        w_rescan   = 1'b1;
                    end
                end
            endcase
            // fresh scan with nothing held
            if (w_rescan) begin
                if (w_b == C_PCT) begin
                    n_pend_cnt = C_PEND_PCT;
                end else begin
                    if (w_k != 2'd3) begin
                        w_bytes[w_k] = w_b;
                        w_k          = w_k + 2'd1;
                    end
                    n_pend_cnt = C_PEND_NONE;
                end
            end
            // flush held escape bytes at end of string
            if (i_in.in_last) begin
                if ((n_pend_cnt != C_PEND_NONE) && (w_k != 2'd3)) begin
                    w_bytes[w_k] = C_PCT;
                    w_k          = w_k + 2'd1;
                end
                if ((n_pend_cnt == C_PEND_HEX) && (w_k != 2'd3)) begin
                    w_bytes[w_k] = n_pend_hex;
                    w_k          = w_k + 2'd1;
                end
                n_pend_cnt = C_PEND_NONE;
                n_pend_hex = 8'h00;
            end
        end
    end

    // Job toward the queue; words that yield nothing are dropped here
    always_comb begin
        o_push.valid     = w_acc && (w_k != 2'd0);
        o_push.job.bytes = w_bytes;
        o_push.job.cnt   = w_k;
        o_push.job.last  = i_in.in_last;
    end

    // Mode register and pending escape state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= C_MODE_ENC;
            r_pend_cnt <= C_PEND_NONE;
            r_pend_hex <= 8'h00;
        end else if (i_cfg_we) begin
            r_mode     <= i_cfg_wdata;
            r_pend_cnt <= C_PEND_NONE;
            r_pend_hex <= 8'h00;
        end else if (w_acc) begin
            r_pend_cnt <= n_pend_cnt;
            r_pend_hex <= n_pend_hex;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pec_queue.sv
// ----------------------------------------------------------------------------
// pec_queue: job queue between classifier and emitter
// Small register FIFO so that input and output stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pec_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pec_pkg::t_push i_push,
    input  wire logic          i_pop,
    output pec_pkg::t_job      o_head,
    output pec_pkg::t_qstat    o_stat
);
    import pec_pkg::*;

    t_job                r_slot [C_Q_DEPTH];
    logic [C_Q_AW-1:0]   r_wptr;
    logic [C_Q_AW-1:0]   r_rptr;
    logic [C_Q_CW-1:0]   r_fill;
    logic                w_wr;
    logic                w_rd;

    assign w_wr = i_push.valid && !o_stat.full;
    assign w_rd = i_pop && !o_stat.empty;

    assign o_stat.full  = (r_fill == C_Q_CW'(C_Q_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_head       = r_slot[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == C_Q_AW'(C_Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == C_Q_AW'(C_Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_fill <= r_fill + C_Q_CW'(1);
                2'b01:   r_fill <= r_fill - C_Q_CW'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    // Job storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wptr] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pec_back.sv
// ----------------------------------------------------------------------------
// pec_back: byte emitter
// Walks the head job one byte per cycle, while the output is taken, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pec_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pec_pkg::t_job   i_head,
    input  wire pec_pkg::t_qstat i_stat,
    output logic               o_pop,
    pec_out_if.source          o_out
);
    import pec_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_idx;
    logic       w_load;
    logic       w_final;

    // Load a new byte when the output stage is free or being taken
    assign w_load  = (!r_valid || o_out.ready) && !i_stat.empty;
    assign w_final = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop   = w_load && w_final;

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

    // Control: output valid and byte index within the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= i_head.last && w_final;
        end
    end

endmodule

`default_nettype wire

>>> rtl/percent_escape_codec_top.sv
// ----------------------------------------------------------------------------
// percent_escape_codec_top: percent-escape encoder/decoder for a byte stream
//
//   channel  direction  payload               handshake
//   i_in     in         in_byte[7:0] in_last  valid/ready
//   o_out    out        out_byte[7:0] out_last valid/ready
//   cfg      in         i_cfg_wdata (mode)    i_cfg_we, no ready
//
// An input word yields zero to three output bytes, which leave one per cycle
// through the registered output stage while the receiver is ready, so an
// escaped byte costs three output bytes and a passed byte one.
// A two-entry job queue parts the classifier from the emitter, so input is
// taken while output stalls until the queue is full.
// Synchronous active-low reset clears mode, pending escape and queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module percent_escape_codec_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    pec_in_if.sink    i_in,
    pec_out_if.source o_out
);
    import pec_pkg::*;

    t_push  w_push;
    t_job   w_head;
    t_qstat w_stat;
    logic   w_pop;

    // Classifier
    pec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_qstat     (w_stat),
        .o_push      (w_push)
    );

    // Job queue
    pec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Emitter
    pec_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // no job offered into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> !w_stat.full)
        else $error("job pushed into full queue");

    // emitter never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

    // end of string always produces at least one byte
    a_last_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.in_last) |-> w_push.valid)
        else $error("last word produced no output");

    // a queued job carries one to three bytes
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> (w_push.job.cnt != 2'd0))
        else $error("empty job pushed");
`endif

endmodule

`default_nettype wire

>>> tb/tb_percent_escape_codec_top.sv
// ----------------------------------------------------------------------------
// tb_percent_escape_codec_top: self-checking bench for the percent-escape codec
// Runs a table of hand-picked words in both modes, then random strings: raw
// bytes in encode mode, and in decode mode valid escapes mixed with broken
// ones and raw bytes. Every result word is checked against typed values or a
// built-in model of the codec, and both sides of the stream stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_percent_escape_codec_top;

    import pec_pkg::*;

    localparam int SETTLE_CYC = 8;    // output pipe drain after the queue runs dry
    localparam int LONG_HOLD  = 120;  // receiver hold-off, fills the job queue
    localparam int RAND_WORDS = 100;
    localparam int IDLE_WORDS = 75;   // random words sent with idling allowed

    typedef struct packed {
        logic [7:0] b;
        logic       lst;
    } t_out_word;

    // One row of the directed table; e holds up to three typed result bytes
    typedef struct packed {
        logic        wr;      // write the mode register before this word
        logic        md;
        logic [7:0]  b;
        logic        lst;
        logic        typed;   // use e/n instead of the model
        logic [1:0]  n;
        logic [23:0] e;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    pec_in_if  in_ch ();
    pec_out_if out_ch ();

    percent_escape_codec_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // Model state and expected output words
    logic       cur_mode;
    logic [1:0] esc_held;
    logic [7:0] esc_digit;
    t_out_word  out_bytes_due[$];

    bit idle_on;
    bit long_hold_req;
    int rx_gap;
    int n_dir, n_rand, n_res, n_err, n_cfg;

    function automatic logic is_upper_hex(input logic [7:0] c);
        return (c inside {["0":"9"], ["A":"F"]});
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        return (c <= "9") ? 4'(c - "0") : 4'(c - "A" + 8'd10);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? ("0" + 8'(v)) : ("A" + 8'(v) - 8'd10);
    endfunction

    // Bytes that encode mode passes through unchanged
    function automatic logic enc_passes(input logic [7:0] c);
        return (c inside {["0":"9"], ["A":"Z"], ["a":"z"], "-", ".", "_", "~",
                          "!", "#", "$", "&", "'", "(", ")", "*", "+", ",",
                          "/", ":", ";", "=", "?", "@", "[", "]"});
    endfunction

    // Converts one input word; returns the number of result bytes in o
    function automatic int percent_convert(input logic [7:0] b, input logic lst,
                                           output logic [2:0][7:0] o);
        int  n;
        logic rescan;
        n = 0;
        rescan = 1'b0;
        o = '0;
        if (cur_mode == C_MODE_ENC) begin
            if (enc_passes(b)) begin
                o[n] = b;
                n++;
            end else begin
                o[0] = C_PCT;
                o[1] = hex_char(b[7:4]);
                o[2] = hex_char(b[3:0]);
                n    = 3;
            end
        end else begin
            case (esc_held)
                C_PEND_NONE: begin
                    rescan = 1'b1;
                end
                C_PEND_PCT: begin
                    if (is_upper_hex(b)) begin
                        esc_digit = b;
                        esc_held  = C_PEND_HEX;
                    end else begin
                        o[n]     = C_PCT;
                        n++;
                        esc_held = C_PEND_NONE;
                        rescan   = 1'b1;
                    end
                end
                default: begin
                    if (is_upper_hex(b)) begin
                        o[n] = {nibble_of(esc_digit), nibble_of(b)};
                        n++;
                    end else begin
                        o[n] = C_PCT;
                        n++;
                        o[n] = esc_digit;
                        n++;
                        rescan = 1'b1;
                    end
                    esc_held = C_PEND_NONE;
                end
            endcase
            // with nothing held or after a broken escape, the current byte is scanned anew
            if (rescan) begin
                if (b == C_PCT) begin
                    esc_held = C_PEND_PCT;
                end else begin
                    o[n] = b;
                    n++;
                end
            end
            // end of string flushes whatever is held
            if (lst) begin
                if (esc_held >= C_PEND_PCT) begin
                    o[n] = C_PCT;
                    n++;
                end
                if (esc_held >= C_PEND_HEX) begin
                    o[n] = esc_digit;
                    n++;
                end
                esc_held  = C_PEND_NONE;
                esc_digit = '0;
            end
        end
        return n;
    endfunction

    function automatic logic [7:0] rand_hex();
        return hex_char(4'($urandom_range(0, 15)));
    endfunction

    // Offers one word, waits for the handshake and queues its results
    task automatic put_word(input logic [7:0] b, input logic lst, input logic typed,
                            input int tn, input logic [23:0] te);
        logic [2:0][7:0] res;
        int n;
        int g;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            g = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n = percent_convert(b, lst, res);
        if (typed) begin
            n   = tn;
            res = {te[7:0], te[15:8], te[23:16]};
        end
        for (int i = 0; i < n; i++) out_bytes_due.push_back('{res[i], lst && (i == n - 1)});
    endtask

    // Drops valid and waits until every result has left the block
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (out_bytes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cur_mode  = m;
        esc_held  = C_PEND_NONE;
        esc_digit = '0;
        n_cfg++;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            rx_gap = LONG_HOLD;
        end else if (rx_gap == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 18);
        end
        if (rx_gap > 0) begin
            out_ch.ready <= 1'b0;
            rx_gap--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Result checker: each accepted word against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_res++;
            if (out_bytes_due.size() == 0) begin
                $display("%0t: unexpected word byte=%02h last=%b", $time,
                         out_ch.out_byte, out_ch.out_last);
                n_err++;
            end else begin
                want = out_bytes_due.pop_front();
                if (out_ch.out_byte !== want.b) begin
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             want.b, out_ch.out_byte);
                    n_err++;
                end
                if (out_ch.out_last !== want.lst) begin
                    $display("%0t: out_last expected %b actual %b", $time,
                             want.lst, out_ch.out_last);
                    n_err++;
                end
            end
        end
    end

    // Hang guard
    initial begin
        #2_000_000;
        $display("timeout, %0d words still expected", out_bytes_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_dir_row        dir_tab [26];
        logic [7:0]      bq[$];
        logic            lq[$];
        logic            md;
        int              len;
        int              ph;

        dir_tab = '{
            // encode: leading zero kept, top byte, pass-through, escaped marks
            '{1'b0, C_MODE_ENC, 8'h00, 1'b0, 1'b1, 2'd3, {"%", "0", "0"}},
            '{1'b0, C_MODE_ENC, 8'hFF, 1'b1, 1'b1, 2'd3, {"%", "F", "F"}},
            '{1'b1, C_MODE_ENC, "A",   1'b0, 1'b1, 2'd1, {"A", 16'h0}},
            '{1'b0, C_MODE_ENC, "~",   1'b0, 1'b1, 2'd1, {"~", 16'h0}},
            '{1'b0, C_MODE_ENC, "%",   1'b0, 1'b1, 2'd3, {"%", "2", "5"}},
            '{1'b0, C_MODE_ENC, 8'h20, 1'b0, 1'b0, 2'd0, 24'h0},
            '{1'b0, C_MODE_ENC, 8'h80, 1'b0, 1'b0, 2'd0, 24'h0},
            '{1'b0, C_MODE_ENC, "?",   1'b1, 1'b1, 2'd1, {"?", 16'h0}},
            // decode: good escape
            '{1'b1, C_MODE_DEC, "%",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "4",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "1",   1'b0, 1'b1, 2'd1, {"A", 16'h0}},
            // lowercase second digit breaks the escape
            '{1'b0, C_MODE_DEC, "%",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "4",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "a",   1'b0, 1'b1, 2'd3, {"%", "4", "a"}},
            // second percent restarts, then end of string flushes
            '{1'b0, C_MODE_DEC, "%",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "%",   1'b0, 1'b1, 2'd1, {"%", 16'h0}},
            '{1'b0, C_MODE_DEC, "F",   1'b1, 1'b1, 2'd2, {"%", "F", 8'h0}},
            '{1'b0, C_MODE_DEC, "%",   1'b1, 1'b1, 2'd1, {"%", 16'h0}},
            '{1'b0, C_MODE_DEC, 8'hFF, 1'b0, 1'b0, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "Z",   1'b1, 1'b0, 2'd0, 24'h0},
            // held escape dropped by a mode write
            '{1'b0, C_MODE_DEC, "%",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "0",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b1, C_MODE_ENC, "z",   1'b0, 1'b1, 2'd1, {"z", 16'h0}},
            '{1'b1, C_MODE_DEC, "%",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "F",   1'b0, 1'b1, 2'd0, 24'h0},
            '{1'b0, C_MODE_DEC, "0",   1'b1, 1'b1, 2'd1, {8'hF0, 16'h0}}
        };

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        rx_gap        = 0;
        cur_mode      = C_MODE_ENC;
        esc_held      = C_PEND_NONE;
        esc_digit     = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].wr) write_mode(dir_tab[i].md);
            put_word(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed,
                     dir_tab[i].n, dir_tab[i].e);
            n_dir++;
        end

        // Random strings, one mode setting per string
        ph = 0;
        while (n_rand < RAND_WORDS) begin
            md = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
            idle_on = (n_rand < IDLE_WORDS) && ($urandom_range(0, 3) != 0);
            write_mode(md);
            bq.delete();
            lq.delete();
            len = $urandom_range(8, 24);
            while (bq.size() < len) begin
                if (md == C_MODE_ENC) begin
                    if ($urandom_range(0, 1) == 0) bq.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    else bq.push_back(8'($urandom_range(0, 255)));
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            bq.push_back(C_PCT);
                            bq.push_back(rand_hex());
                            bq.push_back(rand_hex());
                        end
                        4, 5: bq.push_back(8'($urandom_range(0, 255)));
                        6: begin
                            bq.push_back(C_PCT);
                            bq.push_back(8'($urandom_range(0, 255)));
                        end
                        7: begin
                            bq.push_back(C_PCT);
                            bq.push_back(rand_hex());
                            bq.push_back(8'($urandom_range(0, 255)));
                        end
                        8: bq.push_back(C_PCT);
                        default: bq.push_back(8'($urandom_range(8'h20, 8'h7E)));
                    endcase
                end
            end
            foreach (bq[i]) lq.push_back((i == bq.size() - 1) || ($urandom_range(0, 11) == 0));
            // one string runs against a stalled receiver
            if (ph == 2) long_hold_req = 1'b1;
            foreach (bq[i]) begin
                put_word(bq[i], lq[i], 1'b0, 0, 24'h0);
                n_rand++;
            end
            ph++;
        end

        settle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (out_bytes_due.size() != 0) begin
            $display("%0d result words never arrived", out_bytes_due.size());
            n_err++;
        end

        $display("Sent %0d table words and %0d random words over %0d mode writes;",
                 n_dir, n_rand, n_cfg);
        $display("checked %0d result words, %0d mismatches.", n_res, n_err);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
